/* design/msw_pkg.sv */
// ----------------------------------------------------------------------------
// msw_pkg: shared types and constants of the mesh stencil weight/index generator
// Holds the fixed field widths, register indexes, reset values, queue depths
// and the divide-by-six digit step used by the weight front end.
// ----------------------------------------------------------------------------
`default_nettype none

package msw_pkg;

  // Fixed field widths
  localparam int unsigned IN_W        = 24;
  localparam int unsigned FLAT_W      = 18;
  localparam int unsigned WEIGHT_W    = 25;
  localparam int unsigned WEIGHT_FRAC = 24;
  localparam int unsigned MESH_W      = 7;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_MESH_SIZE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ASSIGN_MODE = 4'd1;

  localparam logic [MESH_W-1:0] MESH_RESET = 7'd32;
  localparam logic              MODE_CUBIC = 1'b1;
  localparam logic              MODE_RESET = MODE_CUBIC;

  // Stencil geometry
  localparam int unsigned AXES        = 3;
  localparam int unsigned STENCIL_MAX = 4;

  // Divider digit size (bits retired per pipeline stage)
  localparam int unsigned DIGIT_W = 8;

  // Queue depths
  localparam int unsigned IN_DEPTH  = 2;
  localparam int unsigned MID_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 4;

  typedef struct packed {
    logic [FLAT_W-1:0]   flat_index;
    logic [WEIGHT_W-1:0] weight;
    logic                last;
  } result_t;

  // One digit of restoring division by six: remainder in, eight dividend bits
  // in; returns {remainder, eight quotient bits}.
  function automatic logic [10:0] div6_digit(input logic [2:0] rem_in,
                                             input logic [7:0] bits);
    logic [3:0] r;
    logic [7:0] q;
    r = {1'b0, rem_in};
    q = '0;
    for (int b = 7; b >= 0; b--) begin
      r = {r[2:0], bits[b]};
      if (r >= 4'd6) begin
        r    = r - 4'd6;
        q[b] = 1'b1;
      end
    end
    return {r[2:0], q};
  endfunction

endpackage

`default_nettype wire

/* design/mesh_stencil_weight_index_gen.sv */
// ----------------------------------------------------------------------------
// mesh_stencil_weight_index_gen: particle-to-mesh stencil generator
// Turns one particle's fractional coordinates into the addresses and weights
// of its cloud-in-cell (2x2x2) or cubic B-spline (4x4x4) mesh stencil.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive frac_x_i/frac_y_i/frac_z_i and raise push;
//   the word is taken on a clock edge where full is low.
//   Result side is a queue: while empty is low the oldest result sits on
//   flat_index_o/weight_o/last_o; raise pop to take it. last_o marks the final
//   point of a particle (8 points linear, 64 points cubic, x slowest, z fastest).
//   Config: cfg_index_i 0 is the mesh size, 1 is assignment_mode; cfg_ready_o
//   is always high. Write only while no particle is in flight.
//   The front end uses one shared multiplier, eight steps per axis in cubic mode.
//   Throughput: one result per cycle while records wait and the result queue has
//   room, set by the single result port; the front end works ahead through
//   a record queue.
//   Reset: mesh size 32, cubic mode, all queues empty.
//   A stalled receiver fills the 4-entry result queue, then the record queue,
//   then the 2-entry input queue, after which full rises; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_stencil_weight_index_gen #(
  parameter int unsigned MAX_MESH  = 64,
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // particle input queue
  input  logic                             push,
  output logic                             full,
  input  logic [msw_pkg::IN_W-1:0]         frac_x_i,
  input  logic [msw_pkg::IN_W-1:0]         frac_y_i,
  input  logic [msw_pkg::IN_W-1:0]         frac_z_i,
  // result output queue
  output logic                             empty,
  input  logic                             pop,
  output logic [msw_pkg::FLAT_W-1:0]       flat_index_o,
  output logic [msw_pkg::WEIGHT_W-1:0]     weight_o,
  output logic                             last_o,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [msw_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [msw_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import msw_pkg::*;

  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned IW   = $clog2(MAX_MESH);
  localparam int unsigned MW   = $clog2(MAX_MESH+1);
  localparam int unsigned CLW  = (MW > MESH_W) ? MW : MESH_W;
  localparam int unsigned RW   = 1 + AXES*IW + AXES*STENCIL_MAX*(F+1);
  localparam int unsigned OW   = FLAT_W + WEIGHT_W + 1;

  logic [MESH_W-1:0]          mesh_cfg_q;
  logic                       assignment_mode_q;
  logic [CLW-1:0]             mesh_ext;
  logic [MW-1:0]              mesh_eff;

  logic                       in_empty, in_pop;
  logic [AXES*F-1:0]          in_frac;
  logic                       rec_full, rec_empty, rec_push, rec_pop;
  logic [RW-1:0]              rec_in, rec_out;
  logic                       res_push;
  result_t                    res_in, res_out;
  logic [$clog2(OUT_DEPTH+1)-1:0] res_count;
  logic [OW-1:0]              res_word;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mesh_cfg_q        <= MESH_RESET;
      assignment_mode_q <= MODE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MESH_SIZE:   mesh_cfg_q        <= cfg_data_i[MESH_W-1:0];
        REG_ASSIGN_MODE: assignment_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Clamp mesh size into the supported range
  always_comb begin
    mesh_ext = CLW'(mesh_cfg_q);
    if (mesh_ext < CLW'(2)) begin
      mesh_eff = MW'(2);
    end else if (mesh_ext > CLW'(MAX_MESH)) begin
      mesh_eff = MW'(MAX_MESH);
    end else begin
      mesh_eff = MW'(mesh_ext);
    end
  end

  // Input queue: keep the low FRAC_BITS bits of each coordinate
  msw_fifo #(
    .WIDTH (AXES*F),
    .DEPTH (IN_DEPTH)
  ) u_in_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && !full),
    .data_i  ({F'(frac_z_i), F'(frac_y_i), F'(frac_x_i)}),
    .full_o  (full),
    .pop_i   (in_pop),
    .data_o  (in_frac),
    .empty_o (in_empty),
    .count_o ()
  );

  msw_front #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_MESH  (MAX_MESH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mesh_i     (mesh_eff),
    .cubic_i    (assignment_mode_q == MODE_CUBIC),
    .in_valid_i (!in_empty),
    .in_frac_i  (in_frac),
    .in_pop_o   (in_pop),
    .rec_full_i (rec_full),
    .rec_push_o (rec_push),
    .rec_o      (rec_in)
  );

  // Record queue between front end and point walker
  msw_fifo #(
    .WIDTH (RW),
    .DEPTH (MID_DEPTH)
  ) u_rec_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .data_i  (rec_in),
    .full_o  (rec_full),
    .pop_i   (rec_pop),
    .data_o  (rec_out),
    .empty_o (rec_empty),
    .count_o ()
  );

  msw_back #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_MESH  (MAX_MESH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mesh_i      (mesh_eff),
    .rec_valid_i (!rec_empty),
    .rec_i       (rec_out),
    .rec_pop_o   (rec_pop),
    .res_count_i (res_count),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // Result queue
  msw_fifo #(
    .WIDTH (OW),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (),
    .pop_i   (pop && !empty),
    .data_o  (res_word),
    .empty_o (empty),
    .count_o (res_count)
  );

  assign res_out      = res_word;
  assign flat_index_o = res_out.flat_index;
  assign weight_o     = res_out.weight;
  assign last_o       = res_out.last;

endmodule

`default_nettype wire

/* design/msw_fifo.sv */
// ----------------------------------------------------------------------------
// msw_fifo: small register-based queue
// First-word-fall-through queue with occupancy count; used at the input, between
// the front end and the back end, and at the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module msw_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == AW'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* design/msw_front.sv */
// ----------------------------------------------------------------------------
// msw_front: per-particle axis setup
// Scales each coordinate by the mesh size, splits cell and offset, and forms
// the axis weights with one shared multiplier and, in cubic mode, a pipelined
// divide-by-six. Emits one record per particle: mode flag, base cells, weights.
// ----------------------------------------------------------------------------
`default_nettype none

module msw_front #(
  parameter int unsigned FRAC_BITS = 24,
  parameter int unsigned MAX_MESH  = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [$clog2(MAX_MESH+1)-1:0]         mesh_i,
  input  logic                                  cubic_i,
  input  logic                                  in_valid_i,
  input  logic [msw_pkg::AXES*FRAC_BITS-1:0]    in_frac_i,
  output logic                                  in_pop_o,
  input  logic                                  rec_full_i,
  output logic                                  rec_push_o,
  output logic [msw_pkg::AXES*$clog2(MAX_MESH)
               + msw_pkg::AXES*msw_pkg::STENCIL_MAX*(FRAC_BITS+1):0] rec_o
);

  import msw_pkg::*;

  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned WW = F + 1;
  localparam int unsigned IW = $clog2(MAX_MESH);
  localparam int unsigned DW = F + 3;
  localparam int unsigned SW = F + 4;
  localparam int unsigned DS = (DW + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned PW = DS * DIGIT_W;
  localparam logic [WW-1:0] ONE = {1'b1, {F{1'b0}}};
  localparam logic [1:0] LAST_AX = 2'(AXES - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  localparam logic [2:0] STEP_SCALE = 3'd0;
  localparam logic [2:0] STEP_G2    = 3'd1;
  localparam logic [2:0] STEP_G3    = 3'd2;
  localparam logic [2:0] STEP_F2    = 3'd3;
  localparam logic [2:0] STEP_F3    = 3'd4;
  localparam logic [2:0] STEP_W1    = 3'd5;
  localparam logic [2:0] STEP_W2    = 3'd6;
  localparam logic [2:0] STEP_W3    = 3'd7;

  typedef struct packed {
    logic [1:0] axis;
    logic [1:0] point;
  } wtag_t;

  logic [1:0]                              state_q;
  logic [1:0]                              ax_q;
  logic [2:0]                              step_q;
  logic                                    cubic_q;
  logic [AXES-1:0][F-1:0]                  frac_q;
  logic [F-1:0]                            f_q, f2_q, f3_q;
  logic [WW-1:0]                           r_q;
  logic [AXES-1:0][IW-1:0]                 base_q;
  logic [AXES-1:0][STENCIL_MAX-1:0][WW-1:0] w_q;

  logic [DS:0]          div_v_q;
  logic [PW-1:0]        div_val_q [DS+1];
  logic [2:0]           div_rem_q [DS+1];
  wtag_t                div_tag_q [DS+1];
  logic [10:0]          digit     [DS];

  logic                 load, run, axis_done;
  logic [WW-1:0]        g, mul_a, mul_b, qm;
  logic [2*F-1:0]       raw;
  logic [IW-1:0]        int_part, base_nx;
  logic signed [SW-1:0] fs, f2s, f3s, ds, num1, num2;
  logic                 issue_v;
  logic [DW-1:0]        issue_val;
  wtag_t                issue_tag;

  assign load      = (state_q == ST_IDLE) && in_valid_i;
  assign run       = (state_q == ST_RUN);
  assign in_pop_o  = load;
  assign axis_done = run && (((step_q == STEP_SCALE) && !cubic_q) || (step_q == STEP_W3));
  assign rec_push_o = (state_q == ST_DRAIN) && !(|div_v_q) && !rec_full_i;
  assign rec_o      = {cubic_q, base_q, w_q};

  // Pick multiplier operands for this step
  assign g = ONE - {1'b0, f_q};
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      STEP_SCALE: begin
        mul_a = {1'b0, frac_q[ax_q]};
        mul_b = WW'(mesh_i);
      end
      STEP_G2: begin
        mul_a = g;
        mul_b = g;
      end
      STEP_G3: begin
        mul_a = r_q;
        mul_b = g;
      end
      STEP_F2: begin
        mul_a = {1'b0, f_q};
        mul_b = {1'b0, f_q};
      end
      STEP_F3: begin
        mul_a = {1'b0, f2_q};
        mul_b = {1'b0, f_q};
      end
      default: ;
    endcase
  end

  // Shared multiplier; fixed-point product passes 1.0 operands through
  assign raw = mul_a[F-1:0] * mul_b[F-1:0];
  assign qm  = mul_a[F] ? mul_b : (mul_b[F] ? mul_a : {1'b0, raw[2*F-1:F]});

  // Cell index and stencil base (cubic starts one cell lower, wrapping)
  assign int_part = raw[F +: IW];
  always_comb begin
    if (!cubic_q) begin
      base_nx = int_part;
    end else if (int_part == '0) begin
      base_nx = IW'(mesh_i - 1'b1);
    end else begin
      base_nx = int_part - 1'b1;
    end
  end

  // Cubic numerators, clamped at zero
  assign fs   = $signed(SW'(f_q));
  assign f2s  = $signed(SW'(f2_q));
  assign f3s  = $signed(SW'(f3_q));
  assign ds   = $signed(SW'(ONE));
  assign num1 = (f3s <<< 1) + f3s - (f2s <<< 2) - (f2s <<< 1) + (ds <<< 2);
  assign num2 = (f2s <<< 1) + f2s + (fs <<< 1) + fs + ds - (f3s <<< 1) - f3s;

  // Select the value sent to the divider
  always_comb begin
    issue_v         = run && cubic_q;
    issue_val       = '0;
    issue_tag.axis  = ax_q;
    issue_tag.point = 2'd0;
    case (step_q)
      STEP_F2: begin
        issue_val       = DW'(r_q);
        issue_tag.point = 2'd0;
      end
      STEP_W1: begin
        issue_val       = num1[SW-1] ? '0 : num1[DW-1:0];
        issue_tag.point = 2'd1;
      end
      STEP_W2: begin
        issue_val       = num2[SW-1] ? '0 : num2[DW-1:0];
        issue_tag.point = 2'd2;
      end
      STEP_W3: begin
        issue_val       = DW'(f3_q);
        issue_tag.point = 2'd3;
      end
      default: issue_v = 1'b0;
    endcase
  end

  // Divide-by-six digit per stage
  always_comb begin
    for (int s = 0; s < DS; s++) begin
      digit[s] = div6_digit(div_rem_q[s], div_val_q[s][PW-1 -: DIGIT_W]);
    end
  end

  // Sequencer and divider valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ax_q    <= '0;
      step_q  <= STEP_SCALE;
      div_v_q <= '0;
    end else begin
      div_v_q <= {div_v_q[DS-1:0], issue_v};
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_RUN;
            ax_q    <= '0;
            step_q  <= STEP_SCALE;
          end
        end
        ST_RUN: begin
          if (axis_done) begin
            step_q <= STEP_SCALE;
            if (ax_q == LAST_AX) begin
              state_q <= ST_DRAIN;
            end else begin
              ax_q <= ax_q + 1'b1;
            end
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (rec_push_o) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (load) begin
      frac_q  <= in_frac_i;
      cubic_q <= cubic_i;
    end
    if (run) begin
      case (step_q)
        STEP_SCALE: begin
          f_q          <= raw[F-1:0];
          base_q[ax_q] <= base_nx;
          if (!cubic_q) begin
            w_q[ax_q][0] <= ONE - {1'b0, raw[F-1:0]};
            w_q[ax_q][1] <= {1'b0, raw[F-1:0]};
          end
        end
        STEP_G2, STEP_G3: r_q <= qm;
        STEP_F2:          f2_q <= qm[F-1:0];
        STEP_F3:          f3_q <= qm[F-1:0];
        default: ;
      endcase
    end
    div_val_q[0] <= PW'(issue_val);
    div_rem_q[0] <= '0;
    div_tag_q[0] <= issue_tag;
    for (int s = 0; s < DS; s++) begin
      div_val_q[s+1] <= {div_val_q[s][PW-DIGIT_W-1:0], digit[s][7:0]};
      div_rem_q[s+1] <= digit[s][10:8];
      div_tag_q[s+1] <= div_tag_q[s];
    end
    // Drop the finished quotient into its weight slot
    if (div_v_q[DS]) begin
      w_q[div_tag_q[DS].axis][div_tag_q[DS].point] <= div_val_q[DS][WW-1:0];
    end
  end

endmodule

`default_nettype wire

/* design/msw_back.sv */
// ----------------------------------------------------------------------------
// msw_back: stencil point walker
// Walks the S x S x S points of one particle record (x slowest, z fastest),
// forms the wrapped flat address and the weight product in two stages, and
// pushes results into the output queue while credit allows.
// ----------------------------------------------------------------------------
`default_nettype none

module msw_back #(
  parameter int unsigned FRAC_BITS = 24,
  parameter int unsigned MAX_MESH  = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [$clog2(MAX_MESH+1)-1:0]         mesh_i,
  input  logic                                  rec_valid_i,
  input  logic [msw_pkg::AXES*$clog2(MAX_MESH)
               + msw_pkg::AXES*msw_pkg::STENCIL_MAX*(FRAC_BITS+1):0] rec_i,
  output logic                                  rec_pop_o,
  input  logic [$clog2(msw_pkg::OUT_DEPTH+1)-1:0] res_count_i,
  output logic                                  res_push_o,
  output msw_pkg::result_t                      res_o
);

  import msw_pkg::*;

  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned WW   = F + 1;
  localparam int unsigned IW   = $clog2(MAX_MESH);
  localparam int unsigned MW   = $clog2(MAX_MESH+1);
  localparam int unsigned RW   = 1 + AXES*IW + AXES*STENCIL_MAX*WW;
  localparam int unsigned WSW  = AXES*STENCIL_MAX*WW;
  localparam int unsigned CW   = $clog2(OUT_DEPTH+1);
  localparam int unsigned XW   = IW + MW + 1;
  localparam int unsigned YW   = FLAT_W + MW + 1;
  localparam int unsigned SH_L = (F < WEIGHT_FRAC) ? WEIGHT_FRAC - F : 0;
  localparam int unsigned SH_R = (F > WEIGHT_FRAC) ? F - WEIGHT_FRAC : 0;
  localparam int unsigned TW   = WW + SH_L;

  function automatic logic [WW-1:0] qmul(input logic [WW-1:0] a, input logic [WW-1:0] b);
    logic [2*F-1:0] prod;
    prod = a[F-1:0] * b[F-1:0];
    if (a[F]) return b;
    if (b[F]) return a;
    return {1'b0, prod[2*F-1:F]};
  endfunction

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] i, input logic [IW-1:0] top);
    return (i == top) ? '0 : i + 1'b1;
  endfunction

  logic                                      rec_cubic;
  logic [AXES-1:0][IW-1:0]                   rec_base;
  logic [AXES-1:0][STENCIL_MAX-1:0][WW-1:0]  rec_w;

  logic                                      busy_q, cubic_q;
  logic [AXES-1:0][IW-1:0]                   base_q;
  logic [AXES-1:0][STENCIL_MAX-1:0][WW-1:0]  w_q;
  logic [1:0]                                ci_q, cj_q, ck_q;
  logic [IW-1:0]                             ix_q, iy_q, iz_q;

  logic                  va_q, vb_q;
  logic [FLAT_W-1:0]     ta_q;
  logic [WW-1:0]         pxy_q, wza_q;
  logic [IW-1:0]         iza_q;
  logic                  lasta_q;
  result_t               res_q;

  logic [1:0]            lim;
  logic                  last_pt, room, issue, load;
  logic [IW-1:0]         m_top;
  logic [XW-1:0]         xy_sum;
  logic [YW-1:0]         flat_sum;
  logic [WW-1:0]         p;
  logic [TW-1:0]         p_ext;

  // Unpack the incoming record
  assign rec_cubic = rec_i[RW-1];
  assign rec_base  = rec_i[RW-2 -: AXES*IW];
  assign rec_w     = rec_i[WSW-1:0];

  assign lim     = cubic_q ? 2'd3 : 2'd1;
  assign last_pt = (ci_q == lim) && (cj_q == lim) && (ck_q == lim);
  assign m_top   = IW'(mesh_i - 1'b1);

  // Issue only with a free slot in the result queue for every point in flight
  assign room  = ((CW+1)'(res_count_i) + (CW+1)'(va_q) + (CW+1)'(vb_q)) < (CW+1)'(OUT_DEPTH);
  assign issue = busy_q && room;
  assign load  = rec_valid_i && (!busy_q || (issue && last_pt));
  assign rec_pop_o = load;

  // Point counters with wrapped mesh indices
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (load) begin
      busy_q <= 1'b1;
    end else if (issue && last_pt) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cubic_q <= rec_cubic;
      base_q  <= rec_base;
      w_q     <= rec_w;
      ci_q    <= '0;
      cj_q    <= '0;
      ck_q    <= '0;
      ix_q    <= rec_base[0];
      iy_q    <= rec_base[1];
      iz_q    <= rec_base[2];
    end else if (issue && !last_pt) begin
      if (ck_q != lim) begin
        ck_q <= ck_q + 1'b1;
        iz_q <= wrap_inc(iz_q, m_top);
      end else begin
        ck_q <= '0;
        iz_q <= base_q[2];
        if (cj_q != lim) begin
          cj_q <= cj_q + 1'b1;
          iy_q <= wrap_inc(iy_q, m_top);
        end else begin
          cj_q <= '0;
          iy_q <= base_q[1];
          ci_q <= ci_q + 1'b1;
          ix_q <= wrap_inc(ix_q, m_top);
        end
      end
    end
  end

  // Stage A: x-y address part and x-y weight product
  assign xy_sum = XW'(ix_q) * XW'(mesh_i) + XW'(iy_q);

  // Stage B: full address and final weight product
  assign flat_sum = YW'(ta_q) * YW'(mesh_i) + YW'(iza_q);
  assign p        = qmul(pxy_q, wza_q);
  assign p_ext    = (TW'(p) << SH_L) >> SH_R;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= issue;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ta_q    <= FLAT_W'(xy_sum);
    pxy_q   <= qmul(w_q[0][ci_q], w_q[1][cj_q]);
    iza_q   <= iz_q;
    wza_q   <= w_q[2][ck_q];
    lasta_q <= last_pt;
    res_q.flat_index <= FLAT_W'(flat_sum);
    res_q.weight     <= WEIGHT_W'(p_ext);
    res_q.last       <= lasta_q;
  end

  assign res_push_o = vb_q;
  assign res_o      = res_q;

endmodule

`default_nettype wire
